>>> hdl/sha1_message_digest_core_defines.svh
// Assertion macros used by the SHA-1 digest core sequencer.
`ifndef SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SMD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("smd: assertion failed");
`define SMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smd: implication failed");
`else
`define SMD_ASSERT(lbl, clk, rst_n, prop)
`define SMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/smd_pkg.sv
// Package with the types, constants and control struct of the SHA-1 digest core.
`default_nettype none
package smd_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam int BLOCK_BYTES     = 64;
  localparam int LEN_POS         = 56;
  localparam int ROUNDS          = 80;
  localparam int DIGEST_WORDS    = 5;
  localparam int SCHED_WORDS     = 16;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } smd_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } smd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } smd_state_t;

  typedef struct packed {
    logic       byte_go;
    logic       word_end;
    logic [7:0] byte_val;
    logic       load_rounds;
    logic       round_en;
    logic [6:0] round_idx;
    logic       add_cv;
    logic       reset_cv;
    logic       emit;
    logic [2:0] word_idx;
  } smd_ctl_t;

endpackage
`default_nettype wire

>>> hdl/smd_sched.sv
// Byte packer and sixteen-word message schedule window.
`default_nettype none
module smd_sched (
  input  wire logic            clk,
  input  wire smd_pkg::smd_ctl_t ctl,
  output logic [31:0]          sched_word
);
  import smd_pkg::*;

  logic [23:0] acc_r;
  logic [23:0] acc_nxt;
  logic [31:0] win_r   [SCHED_WORDS];
  logic [31:0] win_nxt [SCHED_WORDS];
  logic [31:0] mix;

  always_comb begin
    mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    if (ctl.round_idx < 7'(SCHED_WORDS)) begin
      sched_word = win_r[0];
    end else begin
      sched_word = {mix[30:0], mix[31]};
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    win_nxt = win_r;
    if (ctl.byte_go) begin
      acc_nxt = {acc_r[15:0], ctl.byte_val};
      if (ctl.word_end) begin
        for (int i = 0; i < SCHED_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[SCHED_WORDS - 1] = {acc_r, ctl.byte_val};
      end
    end else if (ctl.round_en) begin
      for (int i = 0; i < SCHED_WORDS - 1; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[SCHED_WORDS - 1] = sched_word;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    win_r <= win_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/smd_round.sv
// Shared SHA-1 round unit with working variables and chaining values.
`default_nettype none
module smd_round (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire smd_pkg::smd_ctl_t ctl,
  input  wire logic [31:0]       sched_word,
  output logic [31:0]            cv_word
);
  import smd_pkg::*;

  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] cv_r   [DIGEST_WORDS];
  logic [31:0] cv_nxt [DIGEST_WORDS];
  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (ctl.round_idx inside {[7'd0:7'd19]}) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K0;
    end else if (ctl.round_idx inside {[7'd20:7'd39]}) begin
      f = b_r ^ c_r ^ d_r;
      k = K1;
    end else if (ctl.round_idx inside {[7'd40:7'd59]}) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K3;
    end
  end

  always_comb begin
    case (ctl.word_idx)
      3'd0:    cv_word = cv_r[0];
      3'd1:    cv_word = cv_r[1];
      3'd2:    cv_word = cv_r[2];
      3'd3:    cv_word = cv_r[3];
      3'd4:    cv_word = cv_r[4];
      default: cv_word = cv_r[4];
    endcase
  end

  always_comb begin
    a_nxt  = a_r;
    b_nxt  = b_r;
    c_nxt  = c_r;
    d_nxt  = d_r;
    e_nxt  = e_r;
    cv_nxt = cv_r;
    if (ctl.load_rounds) begin
      a_nxt = cv_r[0];
      b_nxt = cv_r[1];
      c_nxt = cv_r[2];
      d_nxt = cv_r[3];
      e_nxt = cv_r[4];
    end else if (ctl.round_en) begin
      a_nxt = {a_r[26:0], a_r[31:27]} + f + e_r + k + sched_word;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
    if (ctl.add_cv) begin
      cv_nxt[0] = cv_r[0] + a_r;
      cv_nxt[1] = cv_r[1] + b_r;
      cv_nxt[2] = cv_r[2] + c_r;
      cv_nxt[3] = cv_r[3] + d_r;
      cv_nxt[4] = cv_r[4] + e_r;
    end else if (ctl.reset_cv) begin
      cv_nxt[0] = H0;
      cv_nxt[1] = H1;
      cv_nxt[2] = H2;
      cv_nxt[3] = H3;
      cv_nxt[4] = H4;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= H0;
      cv_r[1] <= H1;
      cv_r[2] <= H2;
      cv_r[3] <= H3;
      cv_r[4] <= H4;
    end else begin
      cv_r <= cv_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/smd_ctrl.sv
// Sequencer for byte loading, padding, compression rounds and digest output.
`default_nettype none
`include "sha1_message_digest_core_defines.svh"
module smd_ctrl #(
  parameter int LENGTH_BITS = smd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire smd_pkg::smd_in_t in_payload,
  input  wire logic             out_free,
  output smd_pkg::smd_ctl_t     ctl
);
  import smd_pkg::*;

  smd_state_t             state_r, state_nxt;
  smd_state_t             resume_r, resume_nxt;
  logic [5:0]             fill_r, fill_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [6:0]             round_r, round_nxt;
  logic [2:0]             len_idx_r, len_idx_nxt;
  logic                   pad_first_r, pad_first_nxt;
  logic [2:0]             word_r, word_nxt;
  logic [63:0]            len64;
  logic [7:0]             len_byte;

  always_comb begin
    len64    = 64'(count_r);
    len_byte = 8'(len64 >> {~len_idx_r, 3'b000});
  end

  always_comb begin
    state_nxt     = state_r;
    resume_nxt    = resume_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    round_nxt     = round_r;
    len_idx_nxt   = len_idx_r;
    pad_first_nxt = pad_first_r;
    word_nxt      = word_r;
    in_ready      = 1'b0;
    ctl           = '0;
    ctl.round_idx = round_r;
    ctl.word_idx  = word_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_payload.end_of_message) begin
            pad_first_nxt = 1'b1;
          end
          if (in_payload.has_byte) begin
            ctl.byte_go  = 1'b1;
            ctl.byte_val = in_payload.data_byte;
            count_nxt    = count_r + LENGTH_BITS'(8);
          end
          if (in_payload.has_byte && fill_r == 6'(BLOCK_BYTES - 1)) begin
            state_nxt  = ST_COMP;
            resume_nxt = in_payload.end_of_message ? ST_PAD : ST_IDLE;
          end else if (in_payload.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.byte_go   = 1'b1;
        ctl.byte_val  = pad_first_r ? PAD_BYTE : 8'h00;
        pad_first_nxt = 1'b0;
        if (fill_r == 6'(BLOCK_BYTES - 1)) begin
          state_nxt  = ST_COMP;
          resume_nxt = ST_PAD;
        end else if (fill_r == 6'(LEN_POS - 1)) begin
          state_nxt   = ST_LEN;
          len_idx_nxt = 3'd0;
        end
      end
      ST_LEN: begin
        ctl.byte_go  = 1'b1;
        ctl.byte_val = len_byte;
        len_idx_nxt  = len_idx_r + 3'd1;
        if (len_idx_r == 3'd7) begin
          state_nxt  = ST_COMP;
          resume_nxt = ST_OUT;
        end
      end
      ST_COMP: begin
        ctl.round_en = 1'b1;
        round_nxt    = round_r + 7'd1;
        if (round_r == 7'(ROUNDS - 1)) begin
          round_nxt = 7'd0;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        ctl.add_cv = 1'b1;
        word_nxt   = 3'd0;
        state_nxt  = resume_r;
      end
      ST_OUT: begin
        if (out_free) begin
          ctl.emit = 1'b1;
          word_nxt = word_r + 3'd1;
          if (word_r == 3'(DIGEST_WORDS - 1)) begin
            ctl.reset_cv = 1'b1;
            count_nxt    = '0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ctl.byte_go) begin
      fill_nxt     = fill_r + 6'd1;
      ctl.word_end = (fill_r[1:0] == 2'b11);
      if (fill_r == 6'(BLOCK_BYTES - 1)) begin
        ctl.load_rounds = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      resume_r    <= ST_IDLE;
      fill_r      <= '0;
      count_r     <= '0;
      round_r     <= '0;
      len_idx_r   <= '0;
      pad_first_r <= 1'b0;
      word_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      resume_r    <= resume_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      round_r     <= round_nxt;
      len_idx_r   <= len_idx_nxt;
      pad_first_r <= pad_first_nxt;
      word_r      <= word_nxt;
    end
  end

  `SMD_ASSERT_IMP(a_len_start, clk, rst_n, state_r == ST_LEN && len_idx_r == 3'd0, fill_r == 6'(LEN_POS))
  `SMD_ASSERT_IMP(a_out_fill, clk, rst_n, state_r == ST_OUT, fill_r == 6'd0)
  `SMD_ASSERT_IMP(a_add_after, clk, rst_n, state_r == ST_ADD, $past(state_r) == ST_COMP && $past(round_r) == 7'(ROUNDS - 1))
  `SMD_ASSERT_IMP(a_comp_entry, clk, rst_n, state_r == ST_COMP && $past(state_r) != ST_COMP, round_r == 7'd0 && fill_r == 6'd0)

endmodule
`default_nettype wire

>>> hdl/sha1_message_digest_core.sv
// Top level of the SHA-1 message digest core with its output register.
// The core hashes a message streamed in at most one byte per transaction and
// returns the five 32-bit digest words, h0 first, after the transaction that
// marks the end of the message; it then starts over with the initial chaining
// values. A byte that does not complete a 64-byte block does not hold off the
// input; one that does holds it off for the rounds, run one per cycle through
// the single shared round unit, and for the chaining add. After the end
// transaction the padding and length bytes are generated into the same block
// buffer at one byte per cycle, pausing for one or two further compressions,
// and the digest words leave through a one-deep output register at up to one
// word per cycle. The input is taken only while the sequencer is idle, which
// includes the time the last digest word waits to be taken.
`default_nettype none
module sha1_message_digest_core #(
  parameter int LENGTH_BITS = smd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire smd_pkg::smd_in_t  in_payload,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output smd_pkg::smd_out_t      out_payload
);
  import smd_pkg::*;

  smd_ctl_t    ctl;
  logic [31:0] sched_word;
  logic [31:0] cv_word;
  logic        out_free;
  logic        out_valid_r, out_valid_nxt;
  smd_out_t    out_payload_r, out_payload_nxt;

  assign out_free    = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  smd_ctrl #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_free   (out_free),
    .ctl        (ctl)
  );

  smd_sched u_sched (
    .clk        (clk),
    .ctl        (ctl),
    .sched_word (sched_word)
  );

  smd_round u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sched_word (sched_word),
    .cv_word    (cv_word)
  );

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_payload_nxt = out_payload_r;
    if (ctl.emit) begin
      out_valid_nxt               = 1'b1;
      out_payload_nxt.digest_word = cv_word;
      out_payload_nxt.word_number = ctl.word_idx;
      out_payload_nxt.final_word  = (ctl.word_idx == 3'(DIGEST_WORDS - 1));
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_payload_r <= out_payload_nxt;
  end

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the SHA-1 message digest core with a built-in digest predictor.
`default_nettype none
module testbench;
  import smd_pkg::*;

  typedef logic [0:4][31:0] digest_t;

  typedef struct packed {
    smd_in_t item;
    logic    known;
    digest_t want;
  } stim_row_t;

  localparam int NUM_ITEMS = 450;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam digest_t NO_DIGEST = '0;
  localparam digest_t EMPTY_DIGEST = {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                      32'h95601890, 32'hafd80709};
  localparam digest_t ABC_DIGEST = {32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                    32'h7850c26c, 32'h9cd0d89d};
  localparam int PAD_EDGE_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
  localparam int NUM_ROWS = 11;
  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, NO_DIGEST},
    '{'{8'h55, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'haa, 1'b1, 1'b0}, 1'b0, NO_DIGEST},
    '{'{8'hff, 1'b0, 1'b1}, 1'b0, NO_DIGEST}
  };

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  smd_in_t  in_payload;
  logic     out_valid;
  logic     out_ready = 1'b0;
  smd_out_t out_payload;

  logic [31:0] chain [5];
  logic [7:0]  blk_bytes [64];
  logic [63:0] bit_total;
  int unsigned blk_fill;
  smd_out_t    pending_words [$];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left;
  int unsigned hold_left = 0;
  int unsigned rx_phase = 0;
  smd_out_t    want_word;

  sha1_message_digest_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_hash();
    chain[0] = H0;
    chain[1] = H1;
    chain[2] = H2;
    chain[3] = H3;
    chain[4] = H4;
    bit_total = '0;
    blk_fill = 0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < ROUNDS; i++) begin
      if (i >= 16) begin
        w[i%16] = rol32(w[(i-3)%16] ^ w[(i-8)%16] ^ w[(i-14)%16] ^ w[i%16], 1);
      end
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol32(a, 5) + f + e + k + w[i%16];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void absorb_byte(logic [7:0] value);
    blk_bytes[blk_fill] = value;
    blk_fill++;
    if (blk_fill == BLOCK_BYTES) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  function automatic void hash_item(smd_in_t item, logic known, digest_t want);
    logic [63:0] len;
    smd_out_t    next_word;
    if (item.has_byte) begin
      absorb_byte(item.data_byte);
      bit_total += 64'd8;
    end
    if (item.end_of_message) begin
      len = bit_total;
      absorb_byte(PAD_BYTE);
      while (blk_fill != LEN_POS) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[63-8*i -: 8]);
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        next_word = smd_out_t'{digest_word: known ? want[i] : chain[i],
                               word_number: 3'(i),
                               final_word: (i == DIGEST_WORDS - 1)};
        pending_words = {pending_words, next_word};
      end
      restart_hash();
    end
  endfunction

  task automatic send_item(smd_in_t item, logic known, digest_t want);
    in_valid <= 1'b1;
    in_payload <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hash_item(item, known, want);
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(15, 40)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  task automatic wait_for_digests();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= 1'b1;
      rx_phase++;
      case (rx_phase[8:7])
        2'd0: hold_left = 0;
        2'd1: if ($urandom_range(0, 2) == 0) hold_left = $urandom_range(1, 3);
        2'd2: if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(4, 15);
        default: hold_left = $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: unexpected word %h number %0d final %b", out_payload.digest_word,
                     out_payload.word_number, out_payload.final_word);
          end
        end else begin
          want_word = pending_words.pop_front();
          if (out_payload.digest_word !== want_word.digest_word ||
              out_payload.word_number !== want_word.word_number ||
              out_payload.final_word !== want_word.final_word) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected %h/%0d/%b, got %h/%0d/%b", want_word.digest_word,
                       want_word.word_number, want_word.final_word, out_payload.digest_word,
                       out_payload.word_number, out_payload.final_word);
            end
          end
        end
      end
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned msg_count;
    int unsigned len;
    int unsigned pick;
    logic tail_byte;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_payload <= '0;
    restart_hash();
    burst_left = $urandom_range(1, 10);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_item(STIM_ROWS[r].item, STIM_ROWS[r].known, STIM_ROWS[r].want);
    end
    wait_for_digests();

    sent = 0;
    msg_count = 0;
    while (sent < NUM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        len = $urandom_range(0, 40);
      end else if (pick < 18) begin
        len = PAD_EDGE_LENS[$urandom_range(0, 7)];
      end else begin
        len = $urandom_range(121, 200);
      end
      tail_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 15) == 0) begin
          send_item(smd_in_t'{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0,
                              end_of_message: 1'b0}, 1'b0, NO_DIGEST);
        end
        send_item(smd_in_t'{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b1,
                            end_of_message: tail_byte && (j == len - 1)}, 1'b0, NO_DIGEST);
        sent++;
      end
      if (!tail_byte) begin
        send_item(smd_in_t'{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0,
                            end_of_message: 1'b1}, 1'b0, NO_DIGEST);
        sent++;
      end
      msg_count++;
      if (msg_count % 4 == 0) wait_for_digests();
    end

    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
